/* hdl/obpt_pkg.sv */
// Shared definitions for the oblique basis point transform.
// Default widths and the configuration register map; no dependencies.
package obpt_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int CFG_IDX_W       = 2;

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER = 2'd0,
    CFG_AXIS_X = 2'd1,
    CFG_AXIS_Y = 2'd2,
    CFG_AXIS_Z = 2'd3
  } cfg_reg_t;

endpackage

/* hdl/oblique_basis_point_transform.sv */
// Oblique basis point transform: pipelined change of basis with Cramer solve.
// Depends on obpt_pkg (defaults, register map).
//
//   channel   handshake               payload
//   request   start (busy tied low)   action, point_x, point_y, point_z
//   result    done, one cycle         out_x, out_y, out_z, degenerate, saturated
//   config    cfg_wr_en               cfg_index, cfg_data
//
// One request per cycle; each result passes through 5 arithmetic stages,
// one divider stage per quotient bit and the output register.
// The quotient pipeline has COORD_WIDTH+2 restoring stages.
// Reset clears valid bits and loads the identity basis with zero center.
// The receiver cannot stall; results leave on the done strobe.
module oblique_basis_point_transform #(
  parameter int COORD_WIDTH = obpt_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = obpt_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  action,
  input  logic signed [COORD_WIDTH-1:0]         point_x,
  input  logic signed [COORD_WIDTH-1:0]         point_y,
  input  logic signed [COORD_WIDTH-1:0]         point_z,
  input  logic                                  cfg_wr_en,
  input  logic [obpt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [3*COORD_WIDTH-1:0]              cfg_data,
  output logic                                  done,
  output logic signed [COORD_WIDTH-1:0]         out_x,
  output logic signed [COORD_WIDTH-1:0]         out_y,
  output logic signed [COORD_WIDTH-1:0]         out_z,
  output logic                                  degenerate,
  output logic                                  saturated
);

  import obpt_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int CW  = 2*W + 1;         // cross product term
  localparam int NW  = 3*W + 4;         // determinants
  localparam int SW  = 2*W + 3;         // back transform sum
  localparam int QB  = W + 2;           // quotient bits kept
  localparam int DVW = NW + F + QB;     // divider datapath
  localparam int LW  = 2*W + 5;         // pre-clamp width
  localparam logic [W-1:0] ONE = W'(1) << F;
  localparam logic signed [LW-1:0] MAXV = (LW'(1) << (W-1)) - LW'(1);
  localparam logic signed [LW-1:0] MINV = ~MAXV;

  // clamp to the coordinate range, returns {clamped, value}
  function automatic logic [W:0] clamp(input logic signed [LW-1:0] t);
    logic [W:0] r;
    if (t > MAXV) r = {1'b1, MAXV[W-1:0]};
    else if (t < MINV) r = {1'b1, MINV[W-1:0]};
    else r = {1'b0, t[W-1:0]};
    return r;
  endfunction

  // truncate toward zero by 2^F, add center, clamp
  function automatic logic [W:0] back_res(input logic signed [SW-1:0] s,
                                          input logic signed [W-1:0] c);
    logic [SW-1:0] mag;
    logic signed [LW-1:0] q;
    mag = s[SW-1] ? SW'(-s) : SW'(s);
    q = $signed(LW'(mag >> F));
    if (s[SW-1]) q = -q;
    return clamp(q + LW'(c));
  endfunction

  assign busy = 1'b0;

  // configuration registers
  logic [3*W-1:0] center, axis_x, axis_y, axis_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      center <= '0;
      axis_x <= (3*W)'(ONE);
      axis_y <= (3*W)'(ONE) << W;
      axis_z <= (3*W)'(ONE) << (2*W);
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CENTER: center <= cfg_data;
        CFG_AXIS_X: axis_x <= cfg_data;
        CFG_AXIS_Y: axis_y <= cfg_data;
        CFG_AXIS_Z: axis_z <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [W-1:0] cv [3], ax [3], ay [3], az [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cv[k] = center[k*W +: W];
      ax[k] = axis_x[k*W +: W];
      ay[k] = axis_y[k*W +: W];
      az[k] = axis_z[k*W +: W];
    end
  end

  // stage 1: offset from center, basis cross products
  logic s1_vld, s1_act;
  logic signed [W:0]    s1_d [3];
  logic signed [CW-1:0] s1_cr [3][3];  // ay x az, az x ax, ax x ay

  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else s1_vld <= start;
    s1_act <= action;
    s1_d[0] <= {point_x[W-1], point_x} - {cv[0][W-1], cv[0]};
    s1_d[1] <= {point_y[W-1], point_y} - {cv[1][W-1], cv[1]};
    s1_d[2] <= {point_z[W-1], point_z} - {cv[2][W-1], cv[2]};
    s1_cr[0][0] <= ay[1]*az[2] - ay[2]*az[1];
    s1_cr[0][1] <= ay[2]*az[0] - ay[0]*az[2];
    s1_cr[0][2] <= ay[0]*az[1] - ay[1]*az[0];
    s1_cr[1][0] <= az[1]*ax[2] - az[2]*ax[1];
    s1_cr[1][1] <= az[2]*ax[0] - az[0]*ax[2];
    s1_cr[1][2] <= az[0]*ax[1] - az[1]*ax[0];
    s1_cr[2][0] <= ax[1]*ay[2] - ax[2]*ay[1];
    s1_cr[2][1] <= ax[2]*ay[0] - ax[0]*ay[2];
    s1_cr[2][2] <= ax[0]*ay[1] - ax[1]*ay[0];
  end

  // stage 2: all products
  logic s2_vld, s2_act;
  logic signed [NW-1:0] s2_pn [3][3];
  logic signed [NW-1:0] s2_pd [3];
  logic signed [CW-1:0] s2_pb [3][3];

  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else s2_vld <= s1_vld;
    s2_act <= s1_act;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++)
        s2_pn[k][j] <= s1_d[j] * s1_cr[k][j];
      s2_pd[k] <= ax[k] * s1_cr[0][k];
      s2_pb[k][0] <= ax[k] * s1_d[0];
      s2_pb[k][1] <= ay[k] * s1_d[1];
      s2_pb[k][2] <= az[k] * s1_d[2];
    end
  end

  // stage 3: determinant sums, finished back transform
  logic s3_vld, s3_act, s3_bsat;
  logic signed [NW-1:0] s3_num [3];
  logic signed [NW-1:0] s3_den;
  logic [2:0][W-1:0]    s3_bk;
  logic [2:0]           s3_bs;
  logic [W:0]           bk_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++)
      bk_r[k] = back_res(SW'(s2_pb[k][0]) + SW'(s2_pb[k][1]) + SW'(s2_pb[k][2]), cv[k]);
  end

  always_ff @(posedge clk) begin
    if (rst) s3_vld <= 1'b0;
    else s3_vld <= s2_vld;
    s3_act <= s2_act;
    s3_den <= s2_pd[0] + s2_pd[1] + s2_pd[2];
    for (int k = 0; k < 3; k++) begin
      s3_num[k] <= s2_pn[k][0] + s2_pn[k][1] + s2_pn[k][2];
      s3_bk[k]  <= bk_r[k][W-1:0];
      s3_bs[k]  <= bk_r[k][W];
    end
  end
  assign s3_bsat = |s3_bs;

  // stage 4: magnitudes, quotient signs, zero determinant
  logic s4_vld, s4_act, s4_degen, s4_bsat;
  logic [2:0][W-1:0] s4_bk;
  logic [NW-1:0] s4_nabs [3];
  logic [NW-1:0] s4_dabs;
  logic [2:0]    s4_neg;

  always_ff @(posedge clk) begin
    if (rst) s4_vld <= 1'b0;
    else s4_vld <= s3_vld;
    s4_act   <= s3_act;
    s4_bk    <= s3_bk;
    s4_bsat  <= s3_bsat;
    s4_degen <= (s3_den == '0);
    s4_dabs  <= s3_den[NW-1] ? NW'(-s3_den) : NW'(s3_den);
    for (int k = 0; k < 3; k++) begin
      s4_nabs[k] <= s3_num[k][NW-1] ? NW'(-s3_num[k]) : NW'(s3_num[k]);
      s4_neg[k]  <= s3_num[k][NW-1] ^ s3_den[NW-1];
    end
  end

  // divider pipeline, one quotient bit per stage
  typedef struct packed {
    logic               act;
    logic               degen;
    logic [2:0][W-1:0]  bk;
    logic               bsat;
    logic [2:0]         neg;
    logic [2:0]         ovf;
    logic [DVW-1:0]     dsh;
    logic [2:0][DVW-1:0] rem;
    logic [2:0][QB-1:0] quo;
  } dv_t;

  dv_t        dv [QB+1];
  logic [QB:0] dv_vld;

  // stage 5: scaled numerator, quotient range check
  always_ff @(posedge clk) begin
    if (rst) dv_vld[0] <= 1'b0;
    else dv_vld[0] <= s4_vld;
    dv[0].act   <= s4_act;
    dv[0].degen <= s4_degen;
    dv[0].bk    <= s4_bk;
    dv[0].bsat  <= s4_bsat;
    dv[0].neg   <= s4_neg;
    dv[0].dsh   <= DVW'(s4_dabs);
    dv[0].quo   <= '0;
    for (int k = 0; k < 3; k++) begin
      dv[0].rem[k] <= DVW'(s4_nabs[k]) << F;
      dv[0].ovf[k] <= (DVW'(s4_nabs[k]) << F) >= (DVW'(s4_dabs) << QB);
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_div
    localparam int B = QB - i;
    dv_t nx;
    always_comb begin
      nx = dv[i-1];
      for (int k = 0; k < 3; k++) begin
        if (dv[i-1].rem[k] >= (dv[i-1].dsh << B)) begin
          nx.rem[k]    = dv[i-1].rem[k] - (dv[i-1].dsh << B);
          nx.quo[k][B] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) dv_vld[i] <= 1'b0;
      else dv_vld[i] <= dv_vld[i-1];
      dv[i] <= nx;
    end
  end

  // output: sign, center, clamp, select action; zeros when degenerate
  logic [W:0]          fw_r [3];
  logic [QB:0]         fmag;
  logic signed [LW-1:0] fq;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fmag = dv[QB].ovf[k] ? ((QB+1)'(1) << QB) : {1'b0, dv[QB].quo[k]};
      fq = $signed(LW'(fmag));
      if (dv[QB].neg[k]) fq = -fq;
      fw_r[k] = clamp(fq + LW'(cv[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= dv_vld[QB];
    if (dv[QB].degen) begin
      out_x <= '0;
      out_y <= '0;
      out_z <= '0;
      saturated <= 1'b0;
    end else if (dv[QB].act) begin
      out_x <= dv[QB].bk[0];
      out_y <= dv[QB].bk[1];
      out_z <= dv[QB].bk[2];
      saturated <= dv[QB].bsat;
    end else begin
      out_x <= fw_r[0][W-1:0];
      out_y <= fw_r[1][W-1:0];
      out_z <= fw_r[2][W-1:0];
      saturated <= fw_r[0][W] | fw_r[1][W] | fw_r[2][W];
    end
    degenerate <= dv[QB].degen;
  end

endmodule
